// File: design/fwk_pkg.sv
// ----------------------------------------------------------------------------
// fwk_pkg
// Shared types and constants for the Fenwick tree add / prefix-sum core.
// ----------------------------------------------------------------------------
package fwk_pkg;

    // Field widths
    localparam int POS_W   = 11;
    localparam int DELTA_W = 32;
    localparam int SUM_W   = 48;

    // Active size after reset
    localparam logic [POS_W-1:0] ACTIVE_RESET = 11'd1024;

    // Operation codes
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Input word
    typedef struct packed {
        logic                      func;
        logic [POS_W-1:0]          position;
        logic signed [DELTA_W-1:0] delta;
    } t_in;

    // Output word
    typedef struct packed {
        logic signed [SUM_W-1:0] prefix_sum;
        logic                    status;
    } t_out;

endpackage

// File: design/fwk_ram.sv
// ----------------------------------------------------------------------------
// fwk_ram
// Partial-sum store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module fwk_ram #(
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [fwk_pkg::SUM_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [fwk_pkg::SUM_W-1:0] o_rdata
);
    import fwk_pkg::*;

    logic [SUM_W-1:0] r_mem [DEPTH];
    logic [SUM_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/fwk_walk.sv
// ----------------------------------------------------------------------------
// fwk_walk
// Tree walk sequencer: clears the store after reset, then runs one add walk
// (read-modify-write per step) or one query walk (read and accumulate per
// step) per input word, and holds the result in an output register.
// ----------------------------------------------------------------------------
module fwk_walk #(
    parameter  int MAX_SIZE = 1024,
    localparam int AW       = $clog2(MAX_SIZE)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  fwk_pkg::t_in              i_in,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output fwk_pkg::t_out             o_out,
    // effective active size
    input  logic [fwk_pkg::POS_W-1:0] i_size,
    // store port
    output logic                      o_ram_we,
    output logic [AW-1:0]             o_ram_waddr,
    output logic [fwk_pkg::SUM_W-1:0] o_ram_wdata,
    output logic                      o_ram_re,
    output logic [AW-1:0]             o_ram_raddr,
    input  logic [fwk_pkg::SUM_W-1:0] i_ram_rdata
);
    import fwk_pkg::*;

    // Walk index width: holds 2*size for the add walk and MAX_SIZE itself
    localparam int WW = (AW + 1 > POS_W + 1) ? AW + 1 : POS_W + 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_SIZE - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WALK  = 4'b0100,
        S_HOLD  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr,   n_clr;
    logic [WW-1:0]    r_idx,   n_idx;
    logic             r_func,  n_func;
    logic [SUM_W-1:0] r_delta, n_delta;
    logic [SUM_W-1:0] r_acc,   n_acc;
    t_out             r_hold,  n_hold;
    logic             r_out_valid, n_out_valid;
    t_out             r_out,   n_out;

    logic             out_free;
    logic             fin;
    t_out             fin_res;
    logic [WW-1:0]    in_pos_w;
    logic [WW-1:0]    size_w;
    logic [WW-1:0]    up_idx;
    logic [WW-1:0]    dn_idx;
    logic [SUM_W-1:0] acc_new;

    // 1-based tree index to store address
    function automatic logic [AW-1:0] addr_of(input logic [WW-1:0] idx);
        logic [WW-1:0] m;
        m = idx - 1'b1;
        return m[AW-1:0];
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_pos_w = {{(WW-POS_W){1'b0}}, i_in.position};
    assign size_w   = {{(WW-POS_W){1'b0}}, i_size};
    // next index: add lowest set bit / clear lowest set bit
    assign up_idx   = r_idx + (r_idx & (~r_idx + 1'b1));
    assign dn_idx   = r_idx & (r_idx - 1'b1);
    assign acc_new  = r_acc + i_ram_rdata;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_idx       = r_idx;
        n_func      = r_func;
        n_delta     = r_delta;
        n_acc       = r_acc;
        n_hold      = r_hold;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        fin         = 1'b0;
        fin_res     = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = '0;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;

        unique case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr;
                n_clr       = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_in.func;
                    n_delta = {{(SUM_W-DELTA_W){i_in.delta[DELTA_W-1]}}, i_in.delta};
                    n_acc   = '0;
                    n_idx   = in_pos_w;
                    if ((i_in.position > i_size) ||
                        (i_in.func == FUNC_ADD && i_in.position == '0)) begin
                        fin            = 1'b1;
                        fin_res.status = STATUS_REJECT;
                    end else if (i_in.position == '0) begin
                        // query at zero: empty sum
                        fin = 1'b1;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = addr_of(in_pos_w);
                        n_state     = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_func == FUNC_ADD) begin
                    // write back this entry, fetch the next one up
                    o_ram_we    = 1'b1;
                    o_ram_waddr = addr_of(r_idx);
                    o_ram_wdata = i_ram_rdata + r_delta;
                    if (up_idx <= size_w) begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = addr_of(up_idx);
                        n_idx       = up_idx;
                    end else begin
                        fin = 1'b1;
                    end
                end else begin
                    n_acc = acc_new;
                    if (dn_idx != '0) begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = addr_of(dn_idx);
                        n_idx       = dn_idx;
                    end else begin
                        fin                = 1'b1;
                        fin_res.prefix_sum = acc_new;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_hold;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hand the result to the output register, or park it
        if (fin) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out       = fin_res;
                n_state     = S_IDLE;
            end else begin
                n_hold  = fin_res;
                n_state = S_HOLD;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_func  <= n_func;
        r_delta <= n_delta;
        r_acc   <= n_acc;
        r_hold  <= n_hold;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: design/fenwick_add_prefix_sum_core.sv
// ----------------------------------------------------------------------------
// fenwick_add_prefix_sum_core
// Binary indexed tree of 48-bit partial sums with add and prefix-sum query.
// ----------------------------------------------------------------------------
// After reset the core clears its MAX_SIZE-entry store, one entry per cycle,
// and holds o_in_stall high while it does so. It then takes one word at a
// time. An add reads and rewrites each tree entry it touches (the write of
// one entry overlaps the read of the next on the store's two ports), and a
// query reads one entry per set bit of its position; either walk touches at
// most floor(log2(active size))+1 entries. A rejected word or a query at
// position zero is answered without touching the store. If the previous
// result is still waiting in the output register when a result is ready,
// the new result is parked until the receiver takes the old one. Results
// leave in order through a one-word output register.
// ----------------------------------------------------------------------------
module fenwick_add_prefix_sum_core #(
    parameter int MAX_SIZE = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  fwk_pkg::t_in              i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output fwk_pkg::t_out             o_out,
    input  logic                      i_cfg_we,
    input  logic [fwk_pkg::POS_W-1:0] i_cfg_wdata
);
    import fwk_pkg::*;

    localparam int AW       = $clog2(MAX_SIZE);
    localparam int SIZE_CAP = (MAX_SIZE > 2047) ? 2047 : MAX_SIZE;
    localparam logic [POS_W-1:0] SIZE_MAX = POS_W'(SIZE_CAP);

    logic [POS_W-1:0] r_active;
    logic [POS_W-1:0] eff_size;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [SUM_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [SUM_W-1:0] ram_rdata;

    // Active size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    // Saturate to the store depth
    assign eff_size = (r_active > SIZE_MAX) ? SIZE_MAX : r_active;

    fwk_walk #(
        .MAX_SIZE (MAX_SIZE)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_size      (eff_size),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    fwk_ram #(
        .DEPTH (MAX_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Fenwick tree add / prefix-sum core.
// ----------------------------------------------------------------------------
// A short directed table covers the index extremes, both operations, the
// rejected cases, a zero size, an oversized size and a size shrink. Random
// phases then follow, each under its own active size. Every accepted word is
// run through a local binary indexed tree. The result words coming out are
// compared in order against the sums that tree predicts, or against the word
// typed into a directed row marked known. Both sides of the handshake idle
// at random in two mixes, then a final stretch runs with no idling at all.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fwk_pkg::*;

    localparam int TREE_DEPTH   = 1024;
    localparam int QUIET_LIMIT  = 4000;   // covers the clearing pass after reset
    localparam int DRAIN_CYCLES = 16;
    localparam int NUM_PHASES   = 6;
    localparam logic KNOWN      = 1'b1;
    localparam logic PREDICTED  = 1'b0;

    // One row of the directed table: a size write or a word
    typedef struct {
        logic             is_cfg;
        logic [POS_W-1:0] cfg_val;
        t_in              word;
        logic             known;
        t_out             sum_word;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in              i_in = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out             o_out;
    logic             i_cfg_we = 1'b0;
    logic [POS_W-1:0] i_cfg_wdata = '0;

    // Local copy of the tree and of the size register
    logic [SUM_W-1:0] tree_sums [1:TREE_DEPTH];
    logic [POS_W-1:0] shadow_size;

    t_out sums_due [$];
    t_out due_word;
    t_row dir_tab [$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned n_fail = 0, n_words = 0, n_adds = 0, n_queries = 0;
    int unsigned n_rejects = 0, n_settings = 0;

    fenwick_add_prefix_sum_core #(
        .MAX_SIZE (TREE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Size in use: the register saturates at the tree depth
    function automatic int unsigned eff_size();
        return (shadow_size > TREE_DEPTH) ? TREE_DEPTH : int'(shadow_size);
    endfunction

    // Apply one word to the local tree and return the result word it yields
    function automatic t_out fenwick_predict(input t_in w);
        int unsigned      lim;
        int unsigned      idx;
        logic [SUM_W-1:0] acc;
        logic [SUM_W-1:0] amount;
        t_out             r;
        lim = eff_size();
        idx = w.position;
        r.prefix_sum = '0;
        r.status     = STATUS_OK;
        amount = {{(SUM_W-DELTA_W){w.delta[DELTA_W-1]}}, w.delta};
        if (idx > lim) begin
            r.status = STATUS_REJECT;
        end else if (w.func == FUNC_QUERY) begin
            acc = '0;
            while (idx != 0) begin
                acc = acc + tree_sums[idx];
                idx = idx & (idx - 1);
            end
            r.prefix_sum = acc;
        end else if (idx == 0) begin
            r.status = STATUS_REJECT;
        end else begin
            while (idx <= lim) begin
                tree_sums[idx] = tree_sums[idx] + amount;
                idx = idx + (idx & (~idx + 1));
            end
        end
        return r;
    endfunction

    function automatic t_row mk_cfg(input logic [POS_W-1:0] v);
        t_row r;
        r = '{is_cfg: 1'b1, cfg_val: v, word: '0, known: 1'b0, sum_word: '0};
        return r;
    endfunction

    function automatic t_row mk_word(input logic f, input logic [POS_W-1:0] pos,
                                     input logic [DELTA_W-1:0] d, input logic kn,
                                     input logic [SUM_W-1:0] xs, input logic xst);
        t_row r;
        r.is_cfg   = 1'b0;
        r.cfg_val  = '0;
        r.word     = '{func: f, position: pos, delta: d};
        r.known    = kn;
        r.sum_word = '{prefix_sum: xs, status: xst};
        return r;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(input t_row r);
        dir_tab = {dir_tab, r};
    endfunction

    // Random word: mostly valid indices, some zero, some anywhere in 11 bits
    function automatic t_in rand_word();
        int unsigned lim;
        int unsigned r;
        t_in         w;
        lim    = eff_size();
        w.func = 1'($urandom_range(1));
        r      = $urandom_range(99);
        if (r < 4 || (lim == 0 && r < 50))
            w.position = '0;
        else if (r < 14 || lim == 0)
            w.position = POS_W'($urandom_range(2047));
        else if (r < 18)
            w.position = POS_W'(lim);
        else
            w.position = POS_W'($urandom_range(lim, 1));
        r = $urandom_range(9);
        if (r < 5)
            w.delta = $urandom;
        else if (r < 8)
            w.delta = $signed($urandom_range(200)) - 100;
        else if (r < 9)
            w.delta = 32'sh7FFF_FFFF;
        else
            w.delta = 32'sh8000_0000;
        return w;
    endfunction

    // Present one word, wait for it to be taken, queue its expected result
    task automatic send_word(input t_in w, input logic use_known, input t_out typed);
        t_out pred;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in       <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        pred = fenwick_predict(w);
        sums_due = {sums_due, (use_known ? typed : pred)};
        n_words++;
        if (w.func == FUNC_QUERY) n_queries++; else n_adds++;
        if (pred.status == STATUS_REJECT) n_rejects++;
    endtask

    // Stop sending and let the core finish everything in flight
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sums_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [POS_W-1:0] v);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_size = v;
        n_settings++;
    endtask

    // Receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (sums_due.size() == 0) begin
                $error("result word with none due: prefix_sum %0d status %0b",
                       o_out.prefix_sum, o_out.status);
                n_fail++;
            end else begin
                due_word = sums_due.pop_front();
                if (o_out.prefix_sum !== due_word.prefix_sum) begin
                    $error("prefix_sum: expected %0d, got %0d",
                           due_word.prefix_sum, o_out.prefix_sum);
                    n_fail++;
                end
                if (o_out.status !== due_word.status) begin
                    $error("status: expected %0b, got %0b", due_word.status, o_out.status);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0)
                     || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results still due",
                     QUIET_LIMIT, sums_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [POS_W-1:0] phase_size [NUM_PHASES];
        int unsigned      phase_words [NUM_PHASES];

        for (int i = 1; i <= TREE_DEPTH; i++) tree_sums[i] = '0;
        shadow_size = ACTIVE_RESET;

        // Cleared store at reset size
        add_row(mk_word(FUNC_QUERY, 0,    32'h1234_5678, KNOWN, 0, STATUS_OK));
        add_row(mk_word(FUNC_QUERY, 1024, 32'h0,         KNOWN, 0, STATUS_OK));
        add_row(mk_word(FUNC_ADD,   0,    32'h5,         KNOWN, 0, STATUS_REJECT));
        add_row(mk_word(FUNC_QUERY, 1025, 32'h0,         KNOWN, 0, STATUS_REJECT));
        add_row(mk_word(FUNC_ADD,   2047, 32'hFFFF_FFFF, KNOWN, 0, STATUS_REJECT));
        add_row(mk_word(FUNC_ADD,   1,    32'h7FFF_FFFF, KNOWN, 0, STATUS_OK));
        add_row(mk_word(FUNC_ADD,   1024, 32'h8000_0000, KNOWN, 0, STATUS_OK));
        add_row(mk_word(FUNC_ADD,   1023, 32'hFFFF_FFFF, KNOWN, 0, STATUS_OK));
        add_row(mk_word(FUNC_QUERY, 1,    32'hFFFF_FFFF, KNOWN,
                        48'h7FFF_FFFF, STATUS_OK));
        add_row(mk_word(FUNC_QUERY, 1024, 32'h0, PREDICTED, 0, STATUS_OK));
        add_row(mk_word(FUNC_ADD,   682,  32'h5555_5555, KNOWN, 0, STATUS_OK));
        add_row(mk_word(FUNC_QUERY, 1365, 32'h0,         KNOWN, 0, STATUS_REJECT));
        add_row(mk_word(FUNC_QUERY, 767,  32'h0, PREDICTED, 0, STATUS_OK));
        // Zero size: only a query at zero passes
        add_row(mk_cfg(0));
        add_row(mk_word(FUNC_QUERY, 0,    32'h0,         KNOWN, 0, STATUS_OK));
        add_row(mk_word(FUNC_QUERY, 1,    32'h0,         KNOWN, 0, STATUS_REJECT));
        add_row(mk_word(FUNC_ADD,   1,    32'h9,         KNOWN, 0, STATUS_REJECT));
        // Oversized register saturates at the tree depth
        add_row(mk_cfg(2047));
        add_row(mk_word(FUNC_QUERY, 1024, 32'h0, PREDICTED, 0, STATUS_OK));
        add_row(mk_word(FUNC_ADD,   1024, 32'd100,       KNOWN, 0, STATUS_OK));
        add_row(mk_word(FUNC_QUERY, 1025, 32'h0,         KNOWN, 0, STATUS_REJECT));
        // Shrink: entries above the new size stay as they were
        add_row(mk_cfg(3));
        add_row(mk_word(FUNC_ADD,   1,    32'd7,         KNOWN, 0, STATUS_OK));
        add_row(mk_word(FUNC_QUERY, 3,    32'h0, PREDICTED, 0, STATUS_OK));
        add_row(mk_word(FUNC_QUERY, 4,    32'h0,         KNOWN, 0, STATUS_REJECT));
        add_row(mk_cfg(1));
        add_row(mk_word(FUNC_ADD,   1,    32'hFFFF_FFF8, KNOWN, 0, STATUS_OK));
        add_row(mk_word(FUNC_QUERY, 1,    32'h0, PREDICTED, 0, STATUS_OK));
        add_row(mk_word(FUNC_QUERY, 2,    32'h0,         KNOWN, 0, STATUS_REJECT));

        // Random phases: size, number of words
        phase_size[0] = 11'd1024;  phase_words[0] = 400;
        phase_size[1] = 11'd37;    phase_words[1] = 300;
        phase_size[2] = 11'd2047;  phase_words[2] = 350;
        phase_size[3] = 11'd0;     phase_words[3] = 80;
        phase_size[4] = 11'd1;     phase_words[4] = 170;
        phase_size[5] = POS_W'($urandom_range(1023, 2));
        phase_words[5] = 400;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        send_idle_pct = 12;
        stall_pct     = 56;
        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                drain();
                set_size(dir_tab[k].cfg_val);
            end else begin
                send_word(dir_tab[k].word, dir_tab[k].known, dir_tab[k].sum_word);
            end
        end

        // Random phases: sender-light idling, then receiver-light, then none
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p / 2)
                0: begin
                    send_idle_pct = 12;
                    stall_pct     = 56;
                end
                1: begin
                    send_idle_pct = 56;
                    stall_pct     = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            drain();
            set_size(phase_size[p]);
            repeat (phase_words[p]) send_word(rand_word(), PREDICTED, '0);
        end

        drain();
        $display("Covered %0d words (%0d adds, %0d queries, %0d rejected) over %0d size writes,",
                 n_words, n_adds, n_queries, n_rejects, n_settings);
        $display("sizes 0, 1, 3, 37, 1024 and 2047 included, under both idle mixes and none.");
        if (n_fail == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
design/fwk_pkg.sv
design/fwk_ram.sv
design/fwk_walk.sv
design/fenwick_add_prefix_sum_core.sv
test/tb.sv
